// File: rtl/core/rhh_pkg.sv
// Package for the Robin Hood hash table: sizes, codes, payload structs and hash constants.
// Used by rhh_hash and robin_hood_hash_table_core; depends on nothing.
package rhh_pkg;

  localparam int unsigned MaxSlots  = 1024;
  localparam int unsigned IdxW      = $clog2(MaxSlots);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned CfgW      = 11;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [63:0] Mix1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] Mix2 = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_DUP      = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SLOTS  = 1'b0,
    REG_REJDUP = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]                 operation;
    logic signed [DataBits-1:0] key;
    logic signed [DataBits-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic signed [DataBits-1:0] found_value;
  } rsp_t;

  // hash unit handshake
  typedef struct packed {
    logic          start;
    logic [CntW-1:0] n;
  } hash_ctl_t;

  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] home;
  } hash_sts_t;

endpackage

// File: rtl/core/rhh_hash.sv
// Multi-cycle home slot unit: mix64 of the sign-extended key, then modulo the slot count.
// Depends on rhh_pkg. Multiplies are 16x64 partial products, the modulo is restoring, 1 bit/cycle.
module rhh_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rhh_pkg::hash_ctl_t          ctl_i,
  input  logic [rhh_pkg::DataBits-1:0] key_i,
  output rhh_pkg::hash_sts_t          sts_o
);

  typedef enum logic [5:0] {
    H_IDLE = 6'b000001,
    H_MUL1 = 6'b000010,
    H_MUL2 = 6'b000100,
    H_FIN  = 6'b001000,
    H_MOD  = 6'b010000,
    H_DONE = 6'b100000
  } hstate_e;

  hstate_e state_q, state_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  part_q, part_d;
  logic [6:0]  bit_q, bit_d;
  logic [rhh_pkg::CntW-1:0] rem_q, rem_d;
  logic [rhh_pkg::CntW-1:0] n_q, n_d;

  logic [63:0] mconst;
  logic [15:0] mslice;
  logic [63:0] pprod;
  logic [rhh_pkg::CntW:0] rem_sh;

  assign mconst = (state_q == H_MUL1) ? rhh_pkg::Mix1 : rhh_pkg::Mix2;
  assign mslice = x_q[part_q*16 +: 16];
  assign pprod  = 64'(mconst * {48'd0, mslice}) << (part_q * 16);
  assign rem_sh = {rem_q, x_q[bit_q[5:0]]};

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    acc_d   = acc_q;
    part_d  = part_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    n_d     = n_q;
    case (state_q)
      H_IDLE: begin
        if (ctl_i.start) begin
          x_d     = {{(64-rhh_pkg::DataBits){key_i[rhh_pkg::DataBits-1]}}, key_i};
          x_d     = x_d ^ (x_d >> 30);
          n_d     = ctl_i.n;
          acc_d   = '0;
          part_d  = '0;
          state_d = H_MUL1;
        end
      end
      H_MUL1, H_MUL2: begin
        acc_d  = acc_q + pprod;
        part_d = part_q + 2'd1;
        if (part_q == 2'd3) begin
          acc_d = '0;
          if (state_q == H_MUL1) begin
            x_d     = (acc_q + pprod) ^ ((acc_q + pprod) >> 27);
            state_d = H_MUL2;
          end else begin
            x_d     = acc_q + pprod;
            state_d = H_FIN;
          end
        end
      end
      H_FIN: begin
        x_d     = x_q ^ (x_q >> 31);
        rem_d   = '0;
        bit_d   = 7'd63;
        state_d = H_MOD;
      end
      H_MOD: begin
        if (rem_sh >= {1'b0, n_q}) begin
          rem_d = rhh_pkg::CntW'(rem_sh - {1'b0, n_q});
        end else begin
          rem_d = rhh_pkg::CntW'(rem_sh);
        end
        bit_d = bit_q - 7'd1;
        if (bit_q == 7'd0) begin
          state_d = H_DONE;
        end
      end
      H_DONE: state_d = H_IDLE;
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    part_q <= part_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    n_q    <= n_d;
  end

  assign sts_o.done = (state_q == H_DONE);
  assign sts_o.home = rem_q[rhh_pkg::IdxW-1:0];

endmodule

// File: rtl/core/robin_hood_hash_table_core.sv
// Robin Hood hash table with linear probing over one slot memory; one item at a time.
// After reset a clearing pass marks all 1024 slots empty, and no item is taken until it
// ends. An item is then hashed (four 16-bit partial products per multiply, one remainder
// bit a cycle over the 64-bit hash), then passes a read state and a check state per probed
// slot on each pass of the read-modify-write walk over the single-port slot memory, and
// holds its result until the receiver takes it; only then is the next item taken. An insert
// that finds a free slot walks the chain twice (check, then place). A walk never revisits
// a slot it has written. Depends on rhh_pkg and rhh_hash.
module robin_hood_hash_table_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rhh_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [rhh_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rhh_pkg::req_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rhh_pkg::rsp_t                       out_data_o
);

  localparam int unsigned IdxW = rhh_pkg::IdxW;
  localparam int unsigned CntW = rhh_pkg::CntW;
  localparam int unsigned DW   = rhh_pkg::DataBits;

  typedef enum logic [7:0] {
    S_CLR   = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_HASH  = 8'b00000100,
    S_CHKRD = 8'b00001000,
    S_CHK   = 8'b00010000,
    S_PLRD  = 8'b00100000,
    S_PL    = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_e;

  typedef struct packed {
    logic [DW-1:0]   key;
    logic [DW-1:0]   value;
    logic [IdxW-1:0] pdist;
    logic            occ;
  } entry_t;

  state_e state_q, state_d;
  logic [CntW-1:0] slots_q;
  logic            rejdup_q;
  logic [IdxW-1:0] clr_q, clr_d;

  rhh_pkg::req_t req_q, req_d;
  entry_t          car_q, car_d;
  logic [IdxW-1:0] idx_q, idx_d, home_q, home_d;
  logic [CntW-1:0] steps_q, steps_d;
  rhh_pkg::rsp_t   rsp_q, rsp_d;

  entry_t mem [rhh_pkg::MaxSlots];
  entry_t rd_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_addr;
  entry_t          mem_wd;

  logic [CntW-1:0] n_eff;
  logic [IdxW-1:0] idx_nx;
  rhh_pkg::hash_ctl_t hctl;
  rhh_pkg::hash_sts_t hsts;

  always_comb begin
    n_eff = slots_q;
    if (slots_q == '0) n_eff = CntW'(1);
    if (slots_q > CntW'(rhh_pkg::MaxSlots)) n_eff = CntW'(rhh_pkg::MaxSlots);
  end

  assign idx_nx = ({1'b0, idx_q} + CntW'(1) == n_eff) ? '0 : IdxW'(idx_q + IdxW'(1));

  assign hctl.start = (state_q == S_IDLE) && in_valid_i;
  assign hctl.n     = n_eff;

  rhh_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (hctl),
    .key_i  (in_data_i.key),
    .sts_o  (hsts)
  );

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    req_d    = req_q;
    car_d    = car_q;
    idx_d    = idx_q;
    home_d   = home_q;
    steps_d  = steps_q;
    rsp_d    = rsp_q;
    mem_we   = 1'b0;
    mem_addr = idx_q;
    mem_wd   = car_q;
    case (state_q)
      S_CLR: begin
        // mark every slot empty
        mem_we   = 1'b1;
        mem_addr = clr_q;
        mem_wd   = '0;
        clr_d    = IdxW'(clr_q + IdxW'(1));
        if (clr_q == IdxW'(rhh_pkg::MaxSlots - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hsts.done) begin
          home_d  = hsts.home;
          idx_d   = hsts.home;
          steps_d = '0;
          car_d   = '{key: req_q.key, value: req_q.value, pdist: '0, occ: 1'b1};
          rsp_d   = '{status: rhh_pkg::ST_NOTFOUND, found_value: '1};
          if (req_q.operation == rhh_pkg::OP_NONE) state_d = S_OUT;
          else state_d = S_CHKRD;
        end
      end
      S_CHKRD: state_d = S_CHK;
      S_CHK: begin
        // rd_q holds slot idx_q
        if (!rd_q.occ) begin
          if (req_q.operation == rhh_pkg::OP_INSERT) begin
            idx_d   = home_q;
            state_d = S_PLRD;
          end else begin
            state_d = S_OUT;
          end
        end else if (req_q.operation == rhh_pkg::OP_INSERT) begin
          if (rejdup_q && rd_q.key == req_q.key) begin
            rsp_d.status = rhh_pkg::ST_DUP;
            state_d      = S_OUT;
          end else if (steps_q + CntW'(1) == n_eff) begin
            rsp_d.status = rhh_pkg::ST_FULL;
            state_d      = S_OUT;
          end else begin
            idx_d   = idx_nx;
            steps_d = steps_q + CntW'(1);
            state_d = S_CHKRD;
          end
        end else if (rd_q.key == req_q.key) begin
          rsp_d = '{status: rhh_pkg::ST_DONE, found_value: rd_q.value};
          mem_wd     = rd_q;
          mem_wd.occ = 1'b0;
          mem_we     = (req_q.operation == rhh_pkg::OP_DELETE);
          state_d    = S_OUT;
        end else if (steps_q + CntW'(1) == n_eff) begin
          state_d = S_OUT;
        end else begin
          idx_d   = idx_nx;
          steps_d = steps_q + CntW'(1);
          state_d = S_CHKRD;
        end
      end
      S_PLRD: state_d = S_PL;
      S_PL: begin
        if (!rd_q.occ) begin
          mem_we  = 1'b1;
          rsp_d.status = rhh_pkg::ST_DONE;
          state_d = S_OUT;
        end else begin
          // swap with a richer resident
          if (rd_q.pdist < car_q.pdist) begin
            mem_we = 1'b1;
            car_d  = rd_q;
          end
          car_d.pdist = IdxW'(car_d.pdist + IdxW'(1));
          idx_d   = idx_nx;
          state_d = S_PLRD;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      slots_q  <= CntW'(rhh_pkg::MaxSlots);
      rejdup_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rhh_pkg::REG_SLOTS:  slots_q  <= cfg_data_i;
          rhh_pkg::REG_REJDUP: rejdup_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_d_reg: begin
      req_q   <= req_d;
      car_q   <= car_d;
      idx_q   <= idx_d;
      home_q  <= home_d;
      steps_q <= steps_d;
      rsp_q   <= rsp_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = rsp_q;

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK || state_q == S_PL) |-> ({1'b0, idx_q} < n_eff))
    else $error("probe index beyond slots in use");
  a_full_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (rsp_q.status == rhh_pkg::ST_FULL || rsp_q.status == rhh_pkg::ST_DUP))
    |-> (req_q.operation == rhh_pkg::OP_INSERT))
    else $error("full or duplicate status on a non-insert");
  a_place_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_PL) |-> mem_wd.occ)
    else $error("placed entry not marked occupied");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(rsp_q))
    else $error("result changed while stalled");
`endif

endmodule
